/* rtl/core/tiep_pkg.sv */
`default_nettype none

package tiep_pkg;

  // Widths of the configuration registers and the mapped pixel coordinates.
  localparam int PARAM_BITS_DEF = 16;
  localparam int CELL_W         = 12;
  localparam int PIX_W          = 14;
  localparam int CFG_W          = 14;
  localparam int CFG_IDX_W      = 2;
  // (2c+1) fits in CELL_W+1 bits; times a PIX_W viewport.
  localparam int PROD_W         = CELL_W + 1 + PIX_W;
  localparam int DEN_W          = CELL_W + 1;

  // Byte codes seen on the terminal input.
  localparam logic [7:0] B_ETX     = 8'd3;
  localparam logic [7:0] B_DC1     = 8'd17;
  localparam logic [7:0] B_ESC     = 8'd27;
  localparam logic [7:0] B_CR      = 8'd13;
  localparam logic [7:0] B_LF      = 8'd10;
  localparam logic [7:0] B_DEL     = 8'd127;
  localparam logic [7:0] B_BS      = 8'd8;
  localparam logic [7:0] B_TAB     = 8'd9;
  localparam logic [7:0] B_SPACE   = 8'd32;
  localparam logic [7:0] B_LBRACK  = 8'h5B;
  localparam logic [7:0] B_LT      = 8'h3C;
  localparam logic [7:0] B_SEMI    = 8'h3B;
  localparam logic [7:0] B_PRESS   = 8'h4D;
  localparam logic [7:0] B_DIG0    = 8'h30;
  localparam logic [7:0] B_DIG9    = 8'h39;
  localparam logic [7:0] B_ARROW_A = 8'h41;
  localparam logic [7:0] B_ARROW_D = 8'h44;

  // Mouse button codes of interest.
  localparam int BTN_LAST_CLICK = 2;
  localparam int BTN_WHEEL_UP   = 64;
  localparam int BTN_WHEEL_DOWN = 65;
  localparam logic signed [7:0] SCROLL_STEP = 8'sd120;

  typedef enum logic [1:0] {
    PH_GROUND = 2'd0,
    PH_ESC    = 2'd1,
    PH_CSI    = 2'd2,
    PH_MOUSE  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_TEXT   = 3'd0,
    EV_KEY    = 3'd1,
    EV_CLICK  = 3'd2,
    EV_SCROLL = 3'd3,
    EV_QUIT   = 3'd4
  } ev_kind_t;

  typedef enum logic [2:0] {
    KEY_ENTER = 3'd0,
    KEY_BKSP  = 3'd1,
    KEY_TAB   = 3'd2,
    KEY_UP    = 3'd3,
    KEY_DOWN  = 3'd4,
    KEY_RIGHT = 3'd5,
    KEY_LEFT  = 3'd6
  } key_t;

  typedef enum logic [1:0] {
    CFG_COLUMNS = 2'd0,
    CFG_ROWS    = 2'd1,
    CFG_VP_W    = 2'd2,
    CFG_VP_H    = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_START = 2'd1,
    ST_WAIT  = 2'd2,
    ST_EMIT  = 2'd3
  } ctl_state_t;

  typedef struct packed {
    logic              hit;
    ev_kind_t          kind;
    key_t              key;
    logic [7:0]        text;
    logic [1:0]        button;
    logic signed [7:0] scroll;
  } ev_t;

  typedef struct packed {
    logic take;
    logic div_start;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_map;
    logic div_done;
    logic out_free;
  } ctl_stat_t;

endpackage

`default_nettype wire

/* rtl/core/tiep_div.sv */
`default_nettype none

module tiep_div #(
  parameter int NUM_W = tiep_pkg::PROD_W,
  parameter int DEN_W = tiep_pkg::DEN_W,
  parameter int Q_W   = tiep_pkg::PIX_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [Q_W-1:0]        quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] quo_r;

  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             fits;
  logic [DEN_W-1:0] rem_nxt;
  logic             last;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    shifted = {rem_r, num_r[NUM_W-1]};
    fits    = shifted >= {1'b0, den_r};
    diff    = shifted - {1'b0, den_r};
    rem_nxt = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    last    = cnt_r == CNT_W'(NUM_W - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      quo_r <= {quo_r[NUM_W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quo  = quo_r[Q_W-1:0];

endmodule

`default_nettype wire

/* rtl/core/tiep_dpath.sv */
`default_nettype none

module tiep_dpath #(
  parameter int PARAM_BITS = tiep_pkg::PARAM_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [tiep_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tiep_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire logic [7:0]                       in_byte,
  input  wire logic                             out_stall,
  input  wire tiep_pkg::ctl_cmd_t               cmd,
  output tiep_pkg::ctl_stat_t                   stat,
  output logic                                  out_valid,
  output logic [2:0]                            out_event_kind,
  output logic [2:0]                            out_key_code,
  output logic [7:0]                            out_text_byte,
  output logic [1:0]                            out_mouse_button,
  output logic                                  out_in_page,
  output logic [tiep_pkg::PIX_W-1:0]            out_page_x,
  output logic [tiep_pkg::PIX_W-1:0]            out_page_y,
  output logic signed [7:0]                     out_scroll_amount
);

  import tiep_pkg::*;

  localparam int PB = PARAM_BITS;

  // Configuration registers.
  logic [CELL_W-1:0] cols_r;
  logic [CELL_W-1:0] rows_r;
  logic [PIX_W-1:0]  vpw_r;
  logic [PIX_W-1:0]  vph_r;

  // Parser state.
  phase_t        phase_r;
  phase_t        phase_nxt;
  logic [1:0]    slot_r;
  logic [1:0]    slot_nxt;
  logic [PB-1:0] params_r   [3];
  logic [PB-1:0] params_nxt [3];

  ev_t           ev;
  ev_t           gnd_ev;
  logic          map_ok;
  logic [7:0]    arrow_off;
  logic [PB+3:0] acc_ext;
  logic [PB+3:0] acc_mul;
  logic [PB-1:0] acc_sat;

  // Pending mouse event while the pixel mapping runs.
  ev_kind_t          pend_kind_r;
  logic [1:0]        pend_button_r;
  logic signed [7:0] pend_scroll_r;

  logic [PROD_W-1:0] prod_x_r;
  logic [PROD_W-1:0] prod_y_r;
  logic [DEN_W-1:0]  cx;
  logic [DEN_W-1:0]  cy;

  logic              done_x;
  logic              done_y;
  logic [PIX_W-1:0]  quo_x;
  logic [PIX_W-1:0]  quo_y;

  logic              out_valid_r;
  logic              load_plain;

  function automatic ev_t ground_ev(input logic [7:0] b);
    ev_t e;
    e = '{hit: 1'b0, kind: EV_TEXT, key: KEY_ENTER, text: 8'd0, button: 2'd0,
          scroll: 8'sd0};
    if (b == B_ETX || b == B_DC1) begin
      e.hit  = 1'b1;
      e.kind = EV_QUIT;
    end else if (b == B_CR || b == B_LF) begin
      e.hit  = 1'b1;
      e.kind = EV_KEY;
      e.key  = KEY_ENTER;
    end else if (b == B_DEL || b == B_BS) begin
      e.hit  = 1'b1;
      e.kind = EV_KEY;
      e.key  = KEY_BKSP;
    end else if (b == B_TAB) begin
      e.hit  = 1'b1;
      e.kind = EV_KEY;
      e.key  = KEY_TAB;
    end else if (b >= B_SPACE && b != B_ESC) begin
      e.hit  = 1'b1;
      e.kind = EV_TEXT;
      e.text = b;
    end
    return e;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= '0;
      rows_r <= '0;
      vpw_r  <= '0;
      vph_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_COLUMNS: cols_r <= cfg_wdata[CELL_W-1:0];
        CFG_ROWS:    rows_r <= cfg_wdata[CELL_W-1:0];
        CFG_VP_W:    vpw_r  <= cfg_wdata[PIX_W-1:0];
        CFG_VP_H:    vph_r  <= cfg_wdata[PIX_W-1:0];
      endcase
    end
  end

  // The map is valid only with all registers set and both cells on the page.
  assign map_ok = (cols_r != '0) && (rows_r != '0) && (vpw_r != '0) && (vph_r != '0) &&
                  (params_r[1] != '0) && (params_r[2] != '0) &&
                  (params_r[1] <= PB'(cols_r)) && (params_r[2] <= PB'(rows_r));

  always_comb begin
    gnd_ev     = ground_ev(in_byte);
    arrow_off  = in_byte - B_ARROW_A;
    acc_ext    = (PB+4)'(params_r[slot_r]);
    acc_mul    = (acc_ext << 3) + (acc_ext << 1) + (PB+4)'(in_byte - B_DIG0);
    acc_sat    = (acc_mul[PB+3:PB] != 4'd0) ? {PB{1'b1}} : acc_mul[PB-1:0];
    phase_nxt  = phase_r;
    slot_nxt   = slot_r;
    params_nxt = params_r;
    ev         = '{hit: 1'b0, kind: EV_TEXT, key: KEY_ENTER, text: 8'd0,
                   button: 2'd0, scroll: 8'sd0};
    unique case (phase_r)
      PH_ESC: begin
        phase_nxt = (in_byte == B_LBRACK) ? PH_CSI : PH_GROUND;
      end
      PH_CSI: begin
        phase_nxt = PH_GROUND;
        if (in_byte >= B_ARROW_A && in_byte <= B_ARROW_D) begin
          ev.hit  = 1'b1;
          ev.kind = EV_KEY;
          ev.key  = key_t'(3'(KEY_UP) + {1'b0, arrow_off[1:0]});
        end else if (in_byte == B_LT) begin
          phase_nxt  = PH_MOUSE;
          params_nxt = '{default: '0};
          slot_nxt   = 2'd0;
        end else begin
          ev = gnd_ev;
          if (in_byte == B_ESC) begin
            phase_nxt = PH_ESC;
          end
        end
      end
      PH_MOUSE: begin
        if (in_byte >= B_DIG0 && in_byte <= B_DIG9) begin
          params_nxt[slot_r] = acc_sat;
        end else if (in_byte == B_SEMI && slot_r < 2'd2) begin
          slot_nxt = slot_r + 2'd1;
        end else begin
          phase_nxt = PH_GROUND;
          if (in_byte == B_PRESS) begin
            if (params_r[0] <= PB'(BTN_LAST_CLICK)) begin
              ev.hit    = 1'b1;
              ev.kind   = EV_CLICK;
              ev.button = params_r[0][1:0];
            end else if (params_r[0] == PB'(BTN_WHEEL_UP) ||
                         params_r[0] == PB'(BTN_WHEEL_DOWN)) begin
              ev.hit    = 1'b1;
              ev.kind   = EV_SCROLL;
              ev.scroll = (params_r[0] == PB'(BTN_WHEEL_UP)) ? SCROLL_STEP : -SCROLL_STEP;
            end
          end
        end
      end
      default: begin
        ev        = gnd_ev;
        phase_nxt = (in_byte == B_ESC) ? PH_ESC : PH_GROUND;
      end
    endcase
  end

  assign stat.need_map = ev.hit && (ev.kind == EV_CLICK || ev.kind == EV_SCROLL) && map_ok;
  assign stat.out_free = !out_valid_r || !out_stall;
  assign stat.div_done = done_x && done_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_GROUND;
      slot_r   <= 2'd0;
      params_r <= '{default: '0};
    end else if (cmd.take) begin
      phase_r  <= phase_nxt;
      slot_r   <= slot_nxt;
      params_r <= params_nxt;
    end
  end

  // Cell c (1-based) maps to (2c-1) * viewport / (2 * cells).
  assign cx = {params_r[1][CELL_W-1:0], 1'b0} - DEN_W'(1);
  assign cy = {params_r[2][CELL_W-1:0], 1'b0} - DEN_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      prod_x_r      <= PROD_W'(cx) * PROD_W'(vpw_r);
      prod_y_r      <= PROD_W'(cy) * PROD_W'(vph_r);
      pend_kind_r   <= ev.kind;
      pend_button_r <= ev.button;
      pend_scroll_r <= ev.scroll;
    end
  end

  tiep_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (prod_x_r),
    .den   ({cols_r, 1'b0}),
    .done  (done_x),
    .quo   (quo_x)
  );

  tiep_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (prod_y_r),
    .den   ({rows_r, 1'b0}),
    .done  (done_y),
    .quo   (quo_y)
  );

  assign load_plain = cmd.take && ev.hit && !stat.need_map;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_plain || cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_event_kind    <= pend_kind_r;
      out_key_code      <= KEY_ENTER;
      out_text_byte     <= 8'd0;
      out_mouse_button  <= pend_button_r;
      out_in_page       <= 1'b1;
      out_page_x        <= quo_x;
      out_page_y        <= quo_y;
      out_scroll_amount <= pend_scroll_r;
    end else if (load_plain) begin
      out_event_kind    <= ev.kind;
      out_key_code      <= ev.key;
      out_text_byte     <= ev.text;
      out_mouse_button  <= ev.button;
      out_in_page       <= 1'b0;
      out_page_x        <= '0;
      out_page_y        <= '0;
      out_scroll_amount <= ev.scroll;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* rtl/core/tiep_ctrl.sv */
`default_nettype none

module tiep_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire tiep_pkg::ctl_stat_t  stat,
  output tiep_pkg::ctl_cmd_t        cmd,
  output logic                      in_stall
);

  import tiep_pkg::*;

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = !stat.out_free;
        if (in_valid && stat.out_free) begin
          cmd.take = 1'b1;
          if (stat.need_map) begin
            state_nxt = ST_START;
          end
        end
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_WAIT;
      end
      ST_WAIT: begin
        if (stat.div_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/terminal_input_event_parser_unit.sv */
// Terminal input event parser. Raw terminal bytes enter one per transfer on the
// in_ channel and at most one event per byte leaves on the out_ channel: quit
// for bytes 3 and 17, enter, backspace, tab and arrow keys, printable or UTF-8
// text bytes, and clicks and wheel scrolls decoded from SGR mouse reports
// (ESC [ < b;x;y M). A mouse press carries the reported cell mapped to a page
// pixel as floor((2c+1)*viewport/(2*cells)) with c the 0-based cell, and
// in_page is set only when all four configuration registers are nonzero and
// the cell lies on the displayed page; otherwise the event still comes out
// with in_page, page_x and page_y zero. Numbers in a mouse report saturate at
// 2^PARAM_BITS - 1. Most bytes are accepted and their event is in the output
// register on the next cycle. A mouse press that needs pixel mapping holds the
// input from its transfer to the next possible one through accept, start, the
// two bit-serial dividers that run side by side over all 27 numerator bits, a
// check that both have finished, and load, which also waits on a stalled
// output. A byte is accepted only when the output register is empty or its
// event leaves in the same cycle, so a waiting event stalls the input.
// Configuration registers are written through cfg_we, cfg_index and cfg_wdata
// and should only change while the block is idle.
`default_nettype none

module terminal_input_event_parser_unit #(
  parameter int PARAM_BITS = tiep_pkg::PARAM_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [tiep_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tiep_pkg::CFG_W-1:0]     cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [2:0]                          out_event_kind,
  output logic [2:0]                          out_key_code,
  output logic [7:0]                          out_text_byte,
  output logic [1:0]                          out_mouse_button,
  output logic                                out_in_page,
  output logic [tiep_pkg::PIX_W-1:0]          out_page_x,
  output logic [tiep_pkg::PIX_W-1:0]          out_page_y,
  output logic signed [7:0]                   out_scroll_amount
);

  import tiep_pkg::*;

  // Commands from the sequencer and status back from the datapath.
  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  // The sequencer decides when a byte is taken and walks the mapping steps.
  tiep_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // The datapath holds the parser state, the registers, the dividers and
  // the output register.
  tiep_dpath #(
    .PARAM_BITS (PARAM_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_byte           (in_byte),
    .out_stall         (out_stall),
    .cmd               (cmd),
    .stat              (stat),
    .out_valid         (out_valid),
    .out_event_kind    (out_event_kind),
    .out_key_code      (out_key_code),
    .out_text_byte     (out_text_byte),
    .out_mouse_button  (out_mouse_button),
    .out_in_page       (out_in_page),
    .out_page_x        (out_page_x),
    .out_page_y        (out_page_y),
    .out_scroll_amount (out_scroll_amount)
  );

  // A byte that needs mapping starts the dividers on the very next cycle.
  a_map_starts_div : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && stat.need_map) |=> cmd.div_start)
    else $error("mapping did not start after a mouse press transfer");

  // A mapped event is only loaded into a free output register.
  a_emit_when_free : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("mapped event loaded over a pending result");

  // A loaded mapped event shows up as a valid result.
  a_emit_shows : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("mapped event did not appear on the output");

  // No byte transfer while a mapped event is being loaded.
  a_no_take_on_emit : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(in_valid && !in_stall))
    else $error("byte accepted while a mapped event was loaded");

endmodule

`default_nettype wire
